FILE: hw/rtl/kfn_pkg.sv
// Shared constants, register indexes and control state type for the keyframe
// novelty check. No dependencies.
package kfn_pkg;

  localparam int MAX_KEYFRAMES_DEF = 1024;

  localparam int POS_W   = 24;
  localparam int QUAT_W  = 16;
  localparam int DIST_W  = 20;
  localparam int COS_W   = 15;
  localparam int CIDX_W  = 10;
  localparam int NEAR_W  = 11;
  localparam int IN_DW   = 136;
  localparam int OUT_DW  = 24;
  localparam int CFG_AW  = 1;

  localparam logic [NEAR_W-1:0] NEARBY_SAT = 11'd1024;
  localparam logic [DIST_W-1:0] DIST_RST   = 20'd1000;
  localparam logic [COS_W-1:0]  COS_RST    = 15'd15826;

  localparam logic [CFG_AW-1:0] CFG_DIST = 1'd0;
  localparam logic [CFG_AW-1:0] CFG_COS  = 1'd1;

  localparam logic KIND_INSERT = 1'b0;
  localparam logic KIND_QUERY  = 1'b1;

  typedef enum logic [2:0] {
    S_IDLE,
    S_SCAN,
    S_DRAIN,
    S_QREAD,
    S_QMUL,
    S_QSUM,
    S_DONE
  } state_t;

endpackage

FILE: hw/rtl/keyframe_novelty_check.sv
// Keyframe table with a novelty test for candidate poses.
// Depends on kfn_pkg.
//
// Channels: in_* carries one request per item; in_tuser is the kind
// (insert or query), in_tdata the pose. out_* returns one result per request.
// cfg_we/cfg_index/cfg_wdata write the distance threshold (index 0) and the
// cosine of half the yaw limit (index 1); write only while the block is idle.
// An insert or a query on an empty table is answered in the next cycle. A
// query on a table of n entries reads one entry per cycle from the pose
// memory, runs it through a four-stage squared-distance pipeline, then
// rereads the nearest entry for the rotation test through the single read
// port of the pose memory, which the scan and the reread share.
// Requests are taken only while no query is in progress and the result
// register is free or being emptied; a stalled receiver holds the result and
// holds off further requests. Reset empties the table and restores the
// register defaults; table contents are not cleared.
module keyframe_novelty_check #(
  parameter int MAX_KEYFRAMES = kfn_pkg::MAX_KEYFRAMES_DEF
) (
  input  logic                        clk,
  input  logic                        rst_n,
  input  logic                        in_tvalid,
  output logic                        in_tready,
  // pos_x[23:0], pos_y[47:24], pos_z[71:48], quat_w[87:72], quat_x[103:88],
  // quat_y[119:104], quat_z[135:120]
  input  logic [kfn_pkg::IN_DW-1:0]   in_tdata,
  // kind
  input  logic                        in_tuser,
  output logic                        out_tvalid,
  input  logic                        out_tready,
  // is_new_keyframe[0], closest_index[10:1], nearby_count[21:11], status[22], zero[23]
  output logic [kfn_pkg::OUT_DW-1:0]  out_tdata,
  input  logic                        cfg_we,
  input  logic [kfn_pkg::CFG_AW-1:0]  cfg_index,
  input  logic [kfn_pkg::DIST_W-1:0]  cfg_wdata
);
  import kfn_pkg::*;

  localparam int IDX_W = (MAX_KEYFRAMES > 1) ? $clog2(MAX_KEYFRAMES) : 1;
  localparam int CNT_W = $clog2(MAX_KEYFRAMES + 1);
  localparam logic [CNT_W-1:0] CNT_MAX = CNT_W'(MAX_KEYFRAMES);
  localparam int D_W   = 50;
  localparam int SQ_W  = 50;
  localparam int AB_W  = POS_W + 1;
  localparam int T2_W  = 2 * DIST_W;
  localparam int NL_W  = T2_W + 4;
  localparam int PR_W  = 2 * QUAT_W;
  localparam int DOT_W = PR_W + 2;

  state_t state_r, state_nxt;

  logic [DIST_W-1:0] dist_r;
  logic [COS_W-1:0]  cos_r;
  logic [T2_W-1:0]   t2_r;
  logic [NL_W-1:0]   near_lim_r;

  logic [CNT_W-1:0]  count_r;
  logic [CNT_W-1:0]  iss_r;

  logic [IN_DW-1:0]  mem [MAX_KEYFRAMES];
  logic [IN_DW-1:0]  mem_q_r;
  logic              rd_en;
  logic [IDX_W-1:0]  rd_addr;

  logic [IN_DW-1:0]  cand_r;

  logic              v1_r, v2_r, v3_r, v4_r;
  logic [IDX_W-1:0]  idx1_r, idx2_r, idx3_r, idx4_r;
  logic [AB_W-1:0]   ax_r, ay_r, az_r;
  logic [SQ_W-1:0]   sx_r, sy_r, sz_r;
  logic [D_W-1:0]    d2_r;

  logic [D_W-1:0]    best_r;
  logic [IDX_W-1:0]  best_i_r;
  logic [NEAR_W-1:0] nearby_r;

  logic signed [PR_W-1:0]  pr_r [4];
  logic signed [DOT_W-1:0] dot_r;

  logic              out_valid_r;
  logic [OUT_DW-1:0] out_data_r;

  logic              in_acc;
  logic              slot_free;
  logic              is_query;
  logic              table_full;
  logic              scan_last;
  logic              pipe_busy;
  logic              start_scan;
  logic              finish;

  function automatic logic [AB_W-1:0] abs_diff(input logic [POS_W-1:0] a,
                                               input logic [POS_W-1:0] b);
    logic signed [AB_W-1:0] d;
    d = $signed({a[POS_W-1], a}) - $signed({b[POS_W-1], b});
    return d[AB_W-1] ? AB_W'(-d) : AB_W'(d);
  endfunction

  assign slot_free  = !out_valid_r || out_tready;
  assign in_acc     = in_tvalid && in_tready;
  assign is_query   = (in_tuser == KIND_QUERY);
  assign table_full = (count_r == CNT_MAX);
  assign scan_last  = (iss_r == count_r - CNT_W'(1));
  assign pipe_busy  = v1_r || v2_r || v3_r || v4_r;
  assign start_scan = in_acc && is_query && (count_r != '0);

  // next state
  always_comb begin
    state_nxt = state_r;
    case (state_r)
      S_IDLE:  if (start_scan) state_nxt = S_SCAN;
      S_SCAN:  if (scan_last) state_nxt = S_DRAIN;
      S_DRAIN: if (!pipe_busy) state_nxt = S_QREAD;
      S_QREAD: state_nxt = S_QMUL;
      S_QMUL:  state_nxt = S_QSUM;
      S_QSUM:  state_nxt = S_DONE;
      S_DONE:  if (slot_free) state_nxt = S_IDLE;
      default: state_nxt = S_IDLE;
    endcase
  end

  // state outputs
  always_comb begin
    in_tready = 1'b0;
    rd_en     = 1'b0;
    rd_addr   = iss_r[IDX_W-1:0];
    finish    = 1'b0;
    case (state_r)
      S_IDLE:  in_tready = slot_free;
      S_SCAN:  rd_en = 1'b1;
      S_QREAD: begin
        rd_en   = 1'b1;
        rd_addr = best_i_r;
      end
      S_DONE:  finish = slot_free;
      default: ;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= S_IDLE;
    end else begin
      state_r <= state_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      dist_r <= DIST_RST;
      cos_r  <= COS_RST;
    end else if (cfg_we) begin
      case (cfg_index)
        CFG_DIST: dist_r <= cfg_wdata;
        CFG_COS:  cos_r  <= cfg_wdata[COS_W-1:0];
        default:  ;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    t2_r       <= dist_r * dist_r;
    near_lim_r <= {t2_r, 3'b000} + NL_W'(t2_r);
  end

  always_ff @(posedge clk) begin
    if (in_acc && !is_query && !table_full) begin
      mem[count_r[IDX_W-1:0]] <= in_tdata;
    end
    if (rd_en) begin
      mem_q_r <= mem[rd_addr];
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      count_r <= '0;
    end else if (in_acc && !is_query && !table_full) begin
      count_r <= count_r + CNT_W'(1);
    end
  end

  always_ff @(posedge clk) begin
    if (start_scan) begin
      cand_r <= in_tdata;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      iss_r <= '0;
    end else if (start_scan) begin
      iss_r <= '0;
    end else if (state_r == S_SCAN) begin
      iss_r <= iss_r + CNT_W'(1);
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v1_r <= 1'b0;
      v2_r <= 1'b0;
      v3_r <= 1'b0;
      v4_r <= 1'b0;
    end else begin
      v1_r <= (state_r == S_SCAN);
      v2_r <= v1_r;
      v3_r <= v2_r;
      v4_r <= v3_r;
    end
  end

  always_ff @(posedge clk) begin
    idx1_r <= iss_r[IDX_W-1:0];
    idx2_r <= idx1_r;
    idx3_r <= idx2_r;
    idx4_r <= idx3_r;
    ax_r   <= abs_diff(cand_r[23:0], mem_q_r[23:0]);
    ay_r   <= abs_diff(cand_r[47:24], mem_q_r[47:24]);
    az_r   <= abs_diff(cand_r[71:48], mem_q_r[71:48]);
    sx_r   <= ax_r * ax_r;
    sy_r   <= ay_r * ay_r;
    sz_r   <= az_r * az_r;
    d2_r   <= sx_r + sy_r + sz_r;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      nearby_r <= '0;
      best_i_r <= '0;
    end else if (start_scan) begin
      nearby_r <= '0;
      best_i_r <= '0;
    end else if (v4_r) begin
      if (({d2_r, 2'b00} <= (D_W + 2)'(near_lim_r)) && (nearby_r < NEARBY_SAT)) begin
        nearby_r <= nearby_r + NEAR_W'(1);
      end
      if ((idx4_r == '0) || (d2_r < best_r)) begin
        best_i_r <= idx4_r;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (v4_r && ((idx4_r == '0) || (d2_r < best_r))) begin
      best_r <= d2_r;
    end
  end

  always_ff @(posedge clk) begin
    for (int k = 0; k < 4; k++) begin
      pr_r[k] <= $signed(cand_r[72 + 16*k +: 16]) * $signed(mem_q_r[72 + 16*k +: 16]);
    end
    dot_r <= DOT_W'(pr_r[0]) + DOT_W'(pr_r[1]) + DOT_W'(pr_r[2]) + DOT_W'(pr_r[3]);
  end

  logic [DOT_W-1:0] dot_abs;
  logic             far;
  logic             rot;
  logic             decide;

  assign dot_abs = dot_r[DOT_W-1] ? DOT_W'(-dot_r) : DOT_W'(dot_r);
  assign far     = best_r > D_W'(t2_r);
  assign rot     = dot_abs < DOT_W'({cos_r, 14'd0});
  assign decide  = far || (rot && (nearby_r <= NEAR_W'(1)));

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (finish || (in_acc && !start_scan)) begin
      out_valid_r <= 1'b1;
    end else if (out_tready) begin
      out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (finish) begin
      out_data_r <= {1'b0, 1'b0, nearby_r, CIDX_W'(best_i_r), decide};
    end else if (in_acc && !start_scan) begin
      out_data_r <= {1'b0, !is_query && table_full, NEAR_W'(0), CIDX_W'(0), is_query};
    end
  end

  assign out_tvalid = out_valid_r;
  assign out_tdata  = out_data_r;

  a_count_bound: assert property (@(posedge clk) disable iff (!rst_n)
    count_r <= CNT_MAX) else $error("keyframe count beyond table size");

  a_full_drop: assert property (@(posedge clk) disable iff (!rst_n)
    in_acc && !is_query && table_full |=> $stable(count_r))
    else $error("insert into full table changed count");

  a_acc_window: assert property (@(posedge clk) disable iff (!rst_n)
    v4_r |-> (state_r == S_SCAN || state_r == S_DRAIN))
    else $error("distance result outside scan");

  a_best_valid: assert property (@(posedge clk) disable iff (!rst_n)
    state_r == S_DONE |-> CNT_W'(best_i_r) < count_r)
    else $error("nearest index outside table");

  a_nearby_sat: assert property (@(posedge clk) disable iff (!rst_n)
    nearby_r <= NEARBY_SAT) else $error("nearby count over saturation");

endmodule

FILE: sim/keyframe_novelty_check_tb.sv
// Testbench for keyframe_novelty_check: drives inserts and queries over the
// stream ports with random gaps and stalls, checks every result against a built-in
// keyframe table predictor or a directed fixed verdict. Depends on kfn_pkg and the block's RTL.
`timescale 1ns / 1ps

module keyframe_novelty_check_tb;
  import kfn_pkg::*;

  localparam int NKEY = MAX_KEYFRAMES_DEF;
  localparam int IDLE_LIMIT = 8000;

  typedef struct {
    logic               kind;
    logic signed [23:0] px, py, pz;
    logic signed [15:0] qw, qx, qy, qz;
  } pose_req_t;

  typedef struct {
    logic        is_new;
    logic [9:0]  idx;
    logic [10:0] near;
    logic        status;
  } verdict_t;

  typedef struct {
    pose_req_t req;
    bit        typed;
    verdict_t  res;
  } dir_row_t;

  logic clk = 0;
  logic rst_n = 0;
  logic in_tvalid = 0;
  logic in_tready;
  logic [IN_DW-1:0] in_tdata = '0;
  logic in_tuser = 0;
  logic out_tvalid;
  logic out_tready = 0;
  logic [OUT_DW-1:0] out_tdata;
  logic cfg_we = 0;
  logic [CFG_AW-1:0] cfg_index = '0;
  logic [DIST_W-1:0] cfg_wdata = '0;

  keyframe_novelty_check u_dut (
    .clk(clk), .rst_n(rst_n),
    .in_tvalid(in_tvalid), .in_tready(in_tready), .in_tdata(in_tdata),
    .in_tuser(in_tuser),
    .out_tvalid(out_tvalid), .out_tready(out_tready), .out_tdata(out_tdata),
    .cfg_we(cfg_we), .cfg_index(cfg_index), .cfg_wdata(cfg_wdata)
  );

  always begin
    #1 clk = 1;
    #1 clk = 0;
  end

  logic signed [23:0] kf_x [NKEY];
  logic signed [23:0] kf_y [NKEY];
  logic signed [23:0] kf_z [NKEY];
  logic signed [15:0] kf_q [NKEY][4];
  int unsigned kf_count = 0;
  logic [DIST_W-1:0] dist_thr = DIST_RST;
  logic [COS_W-1:0] cos_lim = COS_RST;

  verdict_t pending_verdicts[$];
  int errors = 0;
  int idle_cycles = 0;
  bit no_idle = 0;
  int stall_left = 0;

  function automatic verdict_t novelty_predict(pose_req_t r);
    verdict_t v;
    longint dx, dy, dz, d2, best, t2, dot;
    int best_i, nearby;
    logic signed [15:0] q[4];
    v = '{default: 0};
    q = '{r.qw, r.qx, r.qy, r.qz};
    if (r.kind == KIND_INSERT) begin
      if (kf_count >= NKEY) begin
        v.status = 1;
      end else begin
        kf_x[kf_count] = r.px;
        kf_y[kf_count] = r.py;
        kf_z[kf_count] = r.pz;
        for (int k = 0; k < 4; k++) kf_q[kf_count][k] = q[k];
        kf_count++;
      end
      return v;
    end
    if (kf_count == 0) begin
      v.is_new = 1;
      return v;
    end
    t2 = longint'(dist_thr) * longint'(dist_thr);
    best = 0;
    best_i = 0;
    nearby = 0;
    for (int i = 0; i < kf_count; i++) begin
      dx = longint'(r.px) - longint'(kf_x[i]);
      dy = longint'(r.py) - longint'(kf_y[i]);
      dz = longint'(r.pz) - longint'(kf_z[i]);
      d2 = dx * dx + dy * dy + dz * dz;
      if (4 * d2 <= 9 * t2 && nearby < NEARBY_SAT) nearby++;
      if (i == 0 || d2 < best) begin
        best = d2;
        best_i = i;
      end
    end
    dot = 0;
    for (int k = 0; k < 4; k++) dot += longint'(q[k]) * longint'(kf_q[best_i][k]);
    if (dot < 0) dot = -dot;
    if (best > t2) v.is_new = 1;
    else v.is_new = (dot < (longint'(cos_lim) << 14)) && nearby <= 1;
    v.idx = best_i[9:0];
    v.near = nearby[10:0];
    return v;
  endfunction

  task automatic report_mismatch(string what, int got, int want);
    $display("mismatch %s: got %0d expected %0d", what, got, want);
    errors++;
  endtask

  always @(posedge clk) begin
    if (rst_n && ((in_tvalid && in_tready) || (out_tvalid && out_tready))) idle_cycles <= 0;
    else idle_cycles <= idle_cycles + 1;
    if (idle_cycles > IDLE_LIMIT) begin
      $display("TB_ERROR");
      $finish;
    end
  end

  always @(posedge clk) begin
    verdict_t w;
    if (out_tvalid && out_tready) begin
      if (pending_verdicts.size() == 0) begin
        report_mismatch("unexpected result", 1, 0);
      end else begin
        w = pending_verdicts[0];
        pending_verdicts.delete(0);
        if (out_tdata[0] !== w.is_new) report_mismatch("is_new_keyframe", out_tdata[0], w.is_new);
        if (out_tdata[10:1] !== w.idx) report_mismatch("closest_index", out_tdata[10:1], w.idx);
        if (out_tdata[21:11] !== w.near) report_mismatch("nearby_count", out_tdata[21:11], w.near);
        if (out_tdata[22] !== w.status) report_mismatch("status", out_tdata[22], w.status);
      end
      stall_left = no_idle ? 0 : $urandom_range(6, 0);
    end
    if (stall_left > 0) begin
      out_tready <= 0;
      stall_left--;
    end else begin
      out_tready <= rst_n;
    end
  end

  task automatic send_request(pose_req_t r, bit typed, verdict_t tv);
    verdict_t v;
    int gap;
    in_tvalid <= 1;
    in_tuser <= r.kind;
    in_tdata <= {r.qz, r.qy, r.qx, r.qw, r.pz, r.py, r.px};
    @(posedge clk);
    while (!in_tready) @(posedge clk);
    v = novelty_predict(r);
    pending_verdicts.push_back(typed ? tv : v);
    gap = no_idle ? 0 : $urandom_range(6, 0);
    if (gap > 0) begin
      in_tvalid <= 0;
      repeat (gap) @(posedge clk);
    end
  endtask

  task automatic drain_and_write(logic [DIST_W-1:0] thr, logic [COS_W-1:0] cl);
    in_tvalid <= 0;
    @(posedge clk);
    while (pending_verdicts.size() != 0) @(posedge clk);
    repeat (4) @(posedge clk);
    cfg_we <= 1;
    cfg_index <= CFG_DIST;
    cfg_wdata <= thr;
    @(posedge clk);
    cfg_index <= CFG_COS;
    cfg_wdata <= DIST_W'(cl);
    @(posedge clk);
    cfg_we <= 0;
    dist_thr = thr;
    cos_lim = cl;
  endtask

  function automatic logic signed [15:0] rand_q();
    return 16'(int'($urandom_range(32768, 0)) - 16384);
  endfunction

  function automatic pose_req_t make_random(bit allow_insert, int spread);
    pose_req_t r;
    int base, rr;
    rr = spread;
    r.kind = (allow_insert && $urandom_range(99, 0) < 30) ? KIND_INSERT : KIND_QUERY;
    if ($urandom_range(9, 0) == 0) begin
      r.px = 24'($urandom);
      r.py = 24'($urandom);
      r.pz = 24'($urandom);
      r.qw = rand_q(); r.qx = rand_q(); r.qy = rand_q(); r.qz = rand_q();
    end else if (kf_count > 0 && $urandom_range(3, 0) != 0) begin
      base = $urandom_range(kf_count - 1, 0);
      r.px = kf_x[base] + 24'(int'($urandom_range(2 * rr, 0)) - rr);
      r.py = kf_y[base] + 24'(int'($urandom_range(2 * rr, 0)) - rr);
      r.pz = kf_z[base] + 24'(int'($urandom_range(2 * rr, 0)) - rr);
      r.qw = kf_q[base][0] + 16'(int'($urandom_range(2000, 0)) - 1000);
      r.qx = kf_q[base][1] + 16'(int'($urandom_range(2000, 0)) - 1000);
      r.qy = kf_q[base][2] + 16'(int'($urandom_range(2000, 0)) - 1000);
      r.qz = kf_q[base][3];
      if ($urandom_range(1, 0)) begin
        r.qw = -r.qw; r.qx = -r.qx; r.qy = -r.qy; r.qz = -r.qz;
      end
    end else begin
      r.px = 24'(int'($urandom_range(2 * rr * 8, 0)) - rr * 8);
      r.py = 24'(int'($urandom_range(2 * rr * 8, 0)) - rr * 8);
      r.pz = 24'(int'($urandom_range(2 * rr * 8, 0)) - rr * 8);
      r.qw = rand_q(); r.qx = rand_q(); r.qy = rand_q(); r.qz = rand_q();
    end
    return r;
  endfunction

  dir_row_t directed[$];
  localparam verdict_t V_OK = '{is_new: 0, idx: 0, near: 0, status: 0};
  localparam verdict_t V_EMPTY = '{is_new: 1, idx: 0, near: 0, status: 0};

  initial begin
    pose_req_t r;
    logic [DIST_W-1:0] thr_set[5];
    logic [COS_W-1:0] cos_set[5];
    directed.push_back('{'{KIND_QUERY, 24'sd0, 24'sd0, 24'sd0, 16'sd16384, 0, 0, 0}, 1, V_EMPTY});
    directed.push_back('{'{KIND_INSERT, 24'sd0, 24'sd0, 24'sd0, 16'sd16384, 0, 0, 0}, 1, V_OK});
    directed.push_back('{'{KIND_QUERY, 24'sd0, 24'sd0, 24'sd0, 16'sd16384, 0, 0, 0}, 0, V_OK});
    directed.push_back('{'{KIND_QUERY, 24'sd1000, 24'sd0, 24'sd0, 16'sd0, 16'sd16384, 0, 0},
                         0, V_OK});
    directed.push_back('{'{KIND_QUERY, 24'sd1001, 24'sd0, 24'sd0, 16'sd16384, 0, 0, 0},
                         0, V_OK});
    directed.push_back('{'{KIND_INSERT, 24'sd8388607, -24'sd8388608, 24'sd8388607,
                           -16'sd16384, 16'sd16384, -16'sd16384, 16'sd16384}, 1, V_OK});
    directed.push_back('{'{KIND_QUERY, -24'sd8388608, 24'sd8388607, -24'sd8388608,
                           16'sd16384, -16'sd16384, 16'sd16384, -16'sd16384}, 0, V_OK});
    directed.push_back('{'{KIND_INSERT, 24'sd500, 24'sd0, 24'sd0, 16'sd15826, 16'sd4240, 0, 0},
                         1, V_OK});
    directed.push_back('{'{KIND_QUERY, 24'sd250, 24'sd0, 24'sd0, 16'sd16384, 0, 0, 0}, 0, V_OK});
    directed.push_back('{'{KIND_QUERY, 24'sd500, 24'sd0, 24'sd0, 16'sd16384, 0, 0, 0}, 0, V_OK});
    directed.push_back('{'{KIND_INSERT, 24'sd0, 24'sd0, 24'sd0, 16'sd16384, 0, 0, 0}, 1, V_OK});
    directed.push_back('{'{KIND_QUERY, 24'sd0, 24'sd0, 24'sd0, 16'sd100, 16'sd200, 16'sd300,
                           -16'sd400}, 0, V_OK});
    directed.push_back('{'{KIND_QUERY, 24'sd9000, 24'sd0, 24'sd0, 16'sd16384, 0, 0, 0}, 0, V_OK});

    repeat (5) @(posedge clk);
    rst_n <= 1;
    @(posedge clk);

    foreach (directed[i]) send_request(directed[i].req, directed[i].typed, directed[i].res);

    thr_set = '{20'd1000, 20'd0, 20'd1048575, 20'($urandom_range(200000, 1)),
                20'($urandom_range(5000, 100))};
    cos_set = '{15'd15826, 15'd0, 15'd16384, 15'd32767, 15'($urandom_range(16384, 0))};
    for (int ph = 0; ph < 5; ph++) begin
      drain_and_write(thr_set[ph], cos_set[ph]);
      no_idle = (ph == 2);
      for (int n = 0; n < 111; n++) begin
        r = make_random(kf_count < 220, (ph == 2) ? 600000 : 3000);
        send_request(r, 0, V_OK);
      end
    end
    no_idle = 0;

    in_tvalid <= 0;
    @(posedge clk);
    while (pending_verdicts.size() != 0) @(posedge clk);
    repeat (20) @(posedge clk);
    if (errors == 0) begin
      $display("TB_OK");
    end else begin
      $display("TB_ERROR");
    end
    $finish;
  end

endmodule
